>>> rtl/dhb_pkg.sv
package dhb_pkg;

    localparam int CMD_W       = 16;
    localparam int PERIOD_W    = 16;
    localparam int DZ_W        = 10;
    localparam int FULL_SCALE  = 1000;
    localparam int MAG_W       = $clog2(FULL_SCALE + 1);
    localparam int PROD_W      = MAG_W + PERIOD_W;
    localparam int RECIP_SHIFT = PROD_W + 10;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(FULL_SCALE) + 1;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'((64'd1 << RECIP_SHIFT) / FULL_SCALE);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500);

    localparam int OP_W = 2;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_TICK  = 2'd0;
    localparam op_t OP_SET   = 2'd1;
    localparam op_t OP_COAST = 2'd2;
    localparam op_t OP_BRAKE = 2'd3;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_LOW  = 2'd0;
    localparam mode_t MODE_HIGH = 2'd1;
    localparam mode_t MODE_FREE = 2'd2;

    localparam int NUM_PINS = 4;
    localparam int PIN_LA   = 0;
    localparam int PIN_LB   = 1;
    localparam int PIN_RA   = 2;
    localparam int PIN_RB   = 3;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_PERIOD    = 2'd0;
    localparam reg_idx_t REG_DEAD_ZONE = 2'd1;
    localparam reg_idx_t REG_BRAKE     = 2'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [DZ_W-1:0]     dead_zone;
        logic                brake;
    } cfg_t;

    typedef struct packed {
        logic              zero;
        logic              neg;
        logic [PROD_W-1:0] prod;
    } chan_prod_t;

    typedef struct packed {
        logic                zero;
        logic                neg;
        logic [PROD_W-1:0]   prod;
        logic [PERIOD_W-1:0] quot;
    } chan_quot_t;

    typedef struct packed {
        op_t        op;
        chan_quot_t left;
        chan_quot_t right;
    } scaled_t;

endpackage

>>> rtl/dhb_if.sv
interface dhb_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [dhb_pkg::OP_W-1:0]          operation;
    logic signed [dhb_pkg::CMD_W-1:0]  left_command;
    logic signed [dhb_pkg::CMD_W-1:0]  right_command;

    modport source (output valid, output operation, output left_command,
                    output right_command, input ready);
    modport sink   (input valid, input operation, input left_command,
                    input right_command, output ready);
endinterface

interface dhb_pin_if;
    logic valid;
    logic ready;
    logic left_pin_a;
    logic left_pin_b;
    logic right_pin_a;
    logic right_pin_b;

    modport source (output valid, output left_pin_a, output left_pin_b,
                    output right_pin_a, output right_pin_b, input ready);
    modport sink   (input valid, input left_pin_a, input left_pin_b,
                    input right_pin_a, input right_pin_b, output ready);
endinterface

>>> rtl/dual_hbridge_slow_decay_pwm.sv
// Path: an accepted command moves through the stage one and stage two registers to the pin
// register, which offers its result transaction. Throughput: one command per cycle unless
// a low pins.ready stalls it; the duty multiply and its reciprocal divide are pipelined
// and all state updates happen in order in the final register stage.
// Reset: rst_n is asynchronous and active low; it forces all pins low, clears the
// counter, compares and levels, and loads the default configuration.
module dual_hbridge_slow_decay_pwm (
    input  logic                          clk,
    input  logic                          rst_n,
    dhb_cmd_if.sink                       cmd,
    dhb_pin_if.source                     pins,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhb_pkg::PADDR_W-1:0]   paddr,
    input  logic [dhb_pkg::PDATA_W-1:0]   pwdata,
    output logic [dhb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import dhb_pkg::*;

    cfg_t    cfg;
    logic    item_valid;
    scaled_t item;
    logic    take;

    dhb_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dhb_cmd_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dhb_bridge_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .pins       (pins)
    );

endmodule

>>> rtl/dhb_apb_regs.sv
module dhb_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhb_pkg::PADDR_W-1:0]   paddr,
    input  logic [dhb_pkg::PDATA_W-1:0]   pwdata,
    output logic [dhb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output dhb_pkg::cfg_t                 cfg
);
    import dhb_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic [DZ_W-1:0]     dead_zone_reg;
    logic                brake_reg;
    logic                wr;
    reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    // A zero period is stored as one.
    assign period_next = (pwdata[PERIOD_W-1:0] == '0) ? PERIOD_W'(1)
                                                      : pwdata[PERIOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            dead_zone_reg <= '0;
            brake_reg     <= 1'b0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_PERIOD:    period_reg    <= period_next;
                REG_DEAD_ZONE: dead_zone_reg <= pwdata[DZ_W-1:0];
                REG_BRAKE:     brake_reg     <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PERIOD:    prdata = PDATA_W'(period_reg);
            REG_DEAD_ZONE: prdata = PDATA_W'(dead_zone_reg);
            REG_BRAKE:     prdata = PDATA_W'(brake_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.period    = period_reg;
    assign cfg.dead_zone = dead_zone_reg;
    assign cfg.brake     = brake_reg;

    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && idx == REG_PERIOD && pwdata[PERIOD_W-1:0] == '0)
        |=> (period_reg == PERIOD_W'(1)))
        else $error("zero period not stored as one");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_reg != '0)
        else $error("period register holds zero");

    a_unused_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && idx != REG_PERIOD && idx != REG_DEAD_ZONE && idx != REG_BRAKE)
        |=> ($stable(period_reg) && $stable(dead_zone_reg) && $stable(brake_reg)))
        else $error("write to unused address changed a register");

endmodule

>>> rtl/dhb_cmd_scale.sv
module dhb_cmd_scale (
    input  logic              clk,
    input  logic              rst_n,
    input  dhb_pkg::cfg_t     cfg,
    dhb_cmd_if.sink           cmd,
    input  logic              take,
    output logic              item_valid,
    output dhb_pkg::scaled_t  item
);
    import dhb_pkg::*;

    localparam logic signed [CMD_W-1:0] FS_POS = CMD_W'(FULL_SCALE);
    localparam logic signed [CMD_W-1:0] FS_NEG = -FS_POS;
    localparam int WIDE_W = PROD_W + RECIP_W;

    logic       v1_reg;
    op_t        op1_reg;
    chan_prod_t left1_reg;
    chan_prod_t right1_reg;
    logic       v2_reg;
    scaled_t    s2_reg;
    logic       adv1;
    logic       adv2;
    chan_prod_t left1_next;
    chan_prod_t right1_next;
    logic [WIDE_W-1:0] left_wide;
    logic [WIDE_W-1:0] right_wide;

    function automatic chan_prod_t prep(input logic signed [CMD_W-1:0] c,
                                        input cfg_t k);
        logic signed [CMD_W-1:0] lim;
        logic [CMD_W-1:0]        absval;
        logic [MAG_W-1:0]        mag;
        chan_prod_t              r;
        lim = c;
        if (c > FS_POS)
            lim = FS_POS;
        else if (c < FS_NEG)
            lim = FS_NEG;
        absval = lim[CMD_W-1] ? CMD_W'(-lim) : CMD_W'(lim);
        mag    = absval[MAG_W-1:0];
        if (k.dead_zone != '0 && DZ_W'(mag) < k.dead_zone)
            mag = '0;
        r.zero = (mag == '0);
        r.neg  = lim[CMD_W-1];
        r.prod = PROD_W'(mag) * PROD_W'(k.period);
        return r;
    endfunction

    assign adv2      = !v2_reg || take;
    assign adv1      = !v1_reg || adv2;
    assign cmd.ready = adv1;

    assign left1_next  = prep(cmd.left_command, cfg);
    assign right1_next = prep(cmd.right_command, cfg);

    // Division by full scale: reciprocal multiply, may come out one low.
    assign left_wide  = WIDE_W'(left1_reg.prod) * WIDE_W'(RECIP_MUL);
    assign right_wide = WIDE_W'(right1_reg.prod) * WIDE_W'(RECIP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= cmd.valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && cmd.valid)
        begin
            op1_reg    <= cmd.operation;
            left1_reg  <= left1_next;
            right1_reg <= right1_next;
        end
        if (adv2 && v1_reg)
        begin
            s2_reg.op         <= op1_reg;
            s2_reg.left.zero  <= left1_reg.zero;
            s2_reg.left.neg   <= left1_reg.neg;
            s2_reg.left.prod  <= left1_reg.prod;
            s2_reg.left.quot  <= left_wide[RECIP_SHIFT +: PERIOD_W];
            s2_reg.right.zero <= right1_reg.zero;
            s2_reg.right.neg  <= right1_reg.neg;
            s2_reg.right.prod <= right1_reg.prod;
            s2_reg.right.quot <= right_wide[RECIP_SHIFT +: PERIOD_W];
        end
    end

    assign item_valid = v2_reg;
    assign item       = s2_reg;

    a_hold_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !take) |=> (v2_reg && $stable(s2_reg)))
        else $error("stage two item lost under stall");

    a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv2) |=> v1_reg)
        else $error("stage one item lost under stall");

    a_quot_low: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (left_wide[RECIP_SHIFT +: PERIOD_W] <= PERIOD_W'(cfg.period)))
        else $error("scaled duty above period");

endmodule

>>> rtl/dhb_bridge_state.sv
module dhb_bridge_state (
    input  logic              clk,
    input  logic              rst_n,
    input  dhb_pkg::cfg_t     cfg,
    input  logic              item_valid,
    input  dhb_pkg::scaled_t  item,
    output logic              take,
    dhb_pin_if.source         pins
);
    import dhb_pkg::*;

    logic [PERIOD_W-1:0]                   cnt_reg;
    logic [PERIOD_W-1:0]                   cnt_next;
    mode_t [NUM_PINS-1:0]                  mode_reg;
    mode_t [NUM_PINS-1:0]                  mode_next;
    logic  [NUM_PINS-1:0]                  lvl_reg;
    logic  [NUM_PINS-1:0]                  lvl_next;
    logic  [NUM_PINS-1:0][PERIOD_W-1:0]    shadow_reg;
    logic  [NUM_PINS-1:0][PERIOD_W-1:0]    shadow_next;
    logic  [NUM_PINS-1:0][PERIOD_W-1:0]    active_reg;
    logic  [NUM_PINS-1:0][PERIOD_W-1:0]    active_next;
    logic  [NUM_PINS-1:0]                  pins_reg;
    logic  [NUM_PINS-1:0]                  pins_next;
    logic                                  out_valid_reg;
    logic                                  apply;
    logic  [PERIOD_W:0]                    cnt_inc;
    logic  [NUM_PINS-1:0]                  act_nz;
    chan_quot_t                            chan [2];
    logic  [1:0][PROD_W-1:0]               back;
    logic  [1:0][PROD_W-1:0]               rem;
    logic  [1:0][PERIOD_W-1:0]             duty;
    mode_t                                 stop_mode;

    assign take  = !out_valid_reg || pins.ready;
    assign apply = item_valid && take;

    assign chan[0]   = item.left;
    assign chan[1]   = item.right;
    assign stop_mode = cfg.brake ? MODE_HIGH : MODE_LOW;
    assign cnt_inc   = {1'b0, cnt_reg} + (PERIOD_W + 1)'(1);

    // The reciprocal quotient is at most one short; fix it from the remainder.
    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            back[ch] = PROD_W'(chan[ch].quot) * PROD_W'(FULL_SCALE);
            rem[ch]  = chan[ch].prod - back[ch];
            duty[ch] = chan[ch].quot
                     + PERIOD_W'(rem[ch] >= PROD_W'(FULL_SCALE));
        end
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        mode_next   = mode_reg;
        lvl_next    = lvl_reg;
        shadow_next = shadow_reg;
        active_next = active_reg;
        unique case (item.op)
            OP_TICK:
            begin
                cnt_next = (cnt_inc >= {1'b0, cfg.period}) ? '0
                                                           : cnt_inc[PERIOD_W-1:0];
                for (int g = 0; g < NUM_PINS; g++)
                begin
                    if (cnt_next == '0)
                    begin
                        active_next[g] = shadow_reg[g];
                        lvl_next[g]    = 1'b1;
                    end
                    if (cnt_next == active_next[g])
                        lvl_next[g] = 1'b0;
                end
            end
            OP_SET:
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    if (chan[ch].zero || duty[ch] == '0)
                    begin
                        mode_next[2*ch]     = stop_mode;
                        mode_next[2*ch + 1] = stop_mode;
                    end
                    else if (!chan[ch].neg)
                    begin
                        mode_next[2*ch]       = MODE_HIGH;
                        mode_next[2*ch + 1]   = MODE_FREE;
                        shadow_next[2*ch + 1] = cfg.period - duty[ch];
                    end
                    else
                    begin
                        mode_next[2*ch + 1] = MODE_HIGH;
                        mode_next[2*ch]     = MODE_FREE;
                        shadow_next[2*ch]   = cfg.period - duty[ch];
                    end
                end
            end
            OP_COAST:
            begin
                for (int g = 0; g < NUM_PINS; g++)
                    mode_next[g] = MODE_LOW;
            end
            OP_BRAKE:
            begin
                for (int g = 0; g < NUM_PINS; g++)
                    mode_next[g] = MODE_HIGH;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        for (int g = 0; g < NUM_PINS; g++)
        begin
            pins_next[g] = (mode_next[g] == MODE_HIGH)
                        || (mode_next[g] == MODE_FREE && lvl_next[g]);
            act_nz[g]    = (active_reg[g] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            mode_reg      <= {NUM_PINS{MODE_LOW}};
            lvl_reg       <= '0;
            shadow_reg    <= '0;
            active_reg    <= '0;
            pins_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (apply)
        begin
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            lvl_reg       <= lvl_next;
            shadow_reg    <= shadow_next;
            active_reg    <= active_next;
            pins_reg      <= pins_next;
            out_valid_reg <= 1'b1;
        end
        else if (pins.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign pins.valid       = out_valid_reg;
    assign pins.left_pin_a  = pins_reg[PIN_LA];
    assign pins.left_pin_b  = pins_reg[PIN_LB];
    assign pins.right_pin_a = pins_reg[PIN_RA];
    assign pins.right_pin_b = pins_reg[PIN_RB];

    a_pair_not_both_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_reg[PIN_LA] == MODE_FREE && mode_reg[PIN_LB] == MODE_FREE)
        && !(mode_reg[PIN_RA] == MODE_FREE && mode_reg[PIN_RB] == MODE_FREE))
        else $error("both pins of one bridge released");

    a_wrap_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && item.op == OP_TICK && cnt_next == '0) |=> (lvl_reg == act_nz))
        else $error("levels wrong after counter wrap");

    a_coast_low: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && item.op == OP_COAST) |=> (out_valid_reg && pins_reg == '0))
        else $error("coast transaction left a pin high");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && item.op == OP_SET)
        |-> (rem[0] < PROD_W'(2 * FULL_SCALE) && rem[1] < PROD_W'(2 * FULL_SCALE)))
        else $error("duty quotient off by more than one");

endmodule
